### hw/rtl/fsip_pkg.sv
// ---------------------------------------------------------------------------
// fsip_pkg: shared types and microcode for the integer format printer
// Transaction payloads, microcode word layout, the control store,
// the dispatch map and the character helpers.
// ---------------------------------------------------------------------------
package fsip_pkg;

  // transaction payloads
  typedef struct packed {
    logic [7:0]  format_char;
    logic [31:0] argument;
  } fsip_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } fsip_out_t;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SEL_C   = 8'h63;
  localparam logic [7:0] CH_SEL_D   = 8'h64;
  localparam logic [7:0] CH_SEL_X   = 8'h78;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_HEX_A   = 8'h37;  // 'A' minus ten

  // divide by ten through reciprocal multiply
  localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;
  localparam int          RecipShift = 35;
  localparam int          QuotW      = 64 - RecipShift;

  // digit counts
  localparam int         DecDigits  = 10;
  localparam logic [3:0] HexLastIdx = 4'd7;  // eight hex digits, index 0..7
  localparam logic [3:0] DecLastCnt = 4'd1;

  // microcode address
  typedef logic [3:0] upc_t;
  localparam upc_t U_IDLE = 4'd0;
  localparam upc_t U_ECHO = 4'd1;
  localparam upc_t U_CHR  = 4'd2;
  localparam upc_t U_X0   = 4'd3;
  localparam upc_t U_X1   = 4'd4;
  localparam upc_t U_HEX  = 4'd5;
  localparam upc_t U_D0   = 4'd6;
  localparam upc_t U_DMUL = 4'd7;
  localparam upc_t U_DDIG = 4'd8;
  localparam upc_t U_DOUT = 4'd9;

  typedef enum logic [1:0] {EM_NONE, EM_ALWAYS, EM_NEG} emit_t;

  typedef enum logic [2:0] {
    CS_CH, CS_ARG, CS_MINUS, CS_ZERO, CS_LX, CS_HEX, CS_DEC
  } csel_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_NEGATE, OP_MUL, OP_DIV_STEP, OP_HEX_SHIFT, OP_DEC_POP
  } op_t;

  typedef enum logic [2:0] {
    J_ALWAYS, J_DISPATCH, J_Q_NZ, J_HEX_MORE, J_DEC_MORE
  } jmp_t;

  typedef enum logic [1:0] {L_NONE, L_ALWAYS, L_EXIT} last_t;

  // one control word
  typedef struct packed {
    logic  take_in;
    emit_t emit;
    csel_t csel;
    op_t   op;
    jmp_t  jmp;
    last_t last;
    upc_t  tgt;
    upc_t  alt;
  } fsip_uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic  go;
    logic  emit;
    logic  last;
    csel_t csel;
    op_t   op;
  } fsip_cmd_t;

  // datapath to sequencer
  typedef struct packed {
    upc_t disp;
    logic arg_neg;
    logic q_nz;
    logic hex_more;
    logic dec_more;
    logic out_free;
  } fsip_status_t;

  // control store
  function automatic fsip_uword_t ucode(upc_t a);
    fsip_uword_t w;
    w = '{take_in: 1'b0, emit: EM_NONE, csel: CS_CH, op: OP_NOP, jmp: J_ALWAYS,
          last: L_NONE, tgt: U_IDLE, alt: U_IDLE};
    case (a)
      U_IDLE: begin
        w.take_in = 1'b1;
        w.op      = OP_LOAD;
        w.jmp     = J_DISPATCH;
      end
      U_ECHO: begin
        w.emit = EM_ALWAYS;
        w.csel = CS_CH;
        w.last = L_ALWAYS;
      end
      U_CHR: begin
        w.emit = EM_ALWAYS;
        w.csel = CS_ARG;
        w.last = L_ALWAYS;
      end
      U_X0: begin
        w.emit = EM_ALWAYS;
        w.csel = CS_ZERO;
        w.tgt  = U_X1;
      end
      U_X1: begin
        w.emit = EM_ALWAYS;
        w.csel = CS_LX;
        w.tgt  = U_HEX;
      end
      U_HEX: begin
        w.emit = EM_ALWAYS;
        w.csel = CS_HEX;
        w.op   = OP_HEX_SHIFT;
        w.jmp  = J_HEX_MORE;
        w.last = L_EXIT;
        w.tgt  = U_HEX;
      end
      U_D0: begin
        w.emit = EM_NEG;
        w.csel = CS_MINUS;
        w.op   = OP_NEGATE;
        w.tgt  = U_DMUL;
      end
      U_DMUL: begin
        w.op  = OP_MUL;
        w.tgt = U_DDIG;
      end
      U_DDIG: begin
        w.op  = OP_DIV_STEP;
        w.jmp = J_Q_NZ;
        w.tgt = U_DMUL;
        w.alt = U_DOUT;
      end
      U_DOUT: begin
        w.emit = EM_ALWAYS;
        w.csel = CS_DEC;
        w.op   = OP_DEC_POP;
        w.jmp  = J_DEC_MORE;
        w.last = L_EXIT;
        w.tgt  = U_DOUT;
      end
      default: begin
        w.tgt = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // entry point for the byte being accepted
  function automatic upc_t dispatch(logic pending, logic [7:0] ch);
    upc_t t;
    t = U_IDLE;
    if (!pending) begin
      if (ch != CH_PERCENT) t = U_ECHO;
    end else begin
      case (ch)
        CH_SEL_C: t = U_CHR;
        CH_SEL_D: t = U_D0;
        CH_SEL_X: t = U_X0;
        default:  t = U_IDLE;
      endcase
    end
    return t;
  endfunction

  // uppercase hex digit
  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n <= 4'd9) ? (CH_ZERO + {4'b0, n}) : (CH_HEX_A + {4'b0, n});
  endfunction

endpackage

### hw/rtl/fsip_seq.sv
// ---------------------------------------------------------------------------
// fsip_seq: microcode sequencer
// Step counter, control store lookup, the dispatch jump and two-way conditional jumps;
// holds the step while an input or an output slot is not available.
// ---------------------------------------------------------------------------
module fsip_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fmt_valid,
  input  fsip_pkg::fsip_status_t st,
  output fsip_pkg::fsip_cmd_t   cmd,
  output logic                  take_in
);

  fsip_pkg::upc_t      upc;
  fsip_pkg::upc_t      upc_next;
  fsip_pkg::fsip_uword_t uw;
  logic                taken;
  logic                emit_act;
  logic                go;

  // control store read
  assign uw      = fsip_pkg::ucode(upc);
  assign take_in = uw.take_in;

  // branch condition
  always_comb begin
    case (uw.jmp)
      fsip_pkg::J_ALWAYS:   taken = 1'b1;
      fsip_pkg::J_DISPATCH: taken = 1'b1;
      fsip_pkg::J_Q_NZ:     taken = st.q_nz;
      fsip_pkg::J_HEX_MORE: taken = st.hex_more;
      fsip_pkg::J_DEC_MORE: taken = st.dec_more;
      default:              taken = 1'b1;
    endcase
  end

  // step advances once input and output sides allow it
  assign emit_act = (uw.emit == fsip_pkg::EM_ALWAYS) ||
                    ((uw.emit == fsip_pkg::EM_NEG) && st.arg_neg);
  assign go = (!uw.take_in || fmt_valid) && (!emit_act || st.out_free);

  always_comb begin
    upc_next = upc;
    if (go) begin
      if (uw.jmp == fsip_pkg::J_DISPATCH) upc_next = st.disp;
      else if (taken)                     upc_next = uw.tgt;
      else                                upc_next = uw.alt;
    end
  end

  // command to the datapath
  always_comb begin
    cmd.go   = go;
    cmd.emit = emit_act;
    cmd.csel = uw.csel;
    cmd.op   = uw.op;
    case (uw.last)
      fsip_pkg::L_ALWAYS: cmd.last = 1'b1;
      fsip_pkg::L_EXIT:   cmd.last = !taken;
      default:            cmd.last = 1'b0;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= fsip_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### hw/rtl/fsip_dp.sv
// ---------------------------------------------------------------------------
// fsip_dp: formatter datapath
// Byte and value registers, divide-by-ten step, digit buffer,
// character select and the output register.
// ---------------------------------------------------------------------------
module fsip_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  fsip_pkg::fsip_cmd_t    cmd,
  input  fsip_pkg::fsip_in_t     fmt_data,
  input  logic                   chr_stall,
  output fsip_pkg::fsip_status_t st,
  output logic                   chr_valid,
  output fsip_pkg::fsip_out_t    chr_data
);

  logic                          pending;
  logic [7:0]                    ch;
  logic [31:0]                   value;
  logic [fsip_pkg::QuotW-1:0]    q;
  logic [3:0]                    cnt;
  logic [3:0]                    dbuf [fsip_pkg::DecDigits];
  logic [63:0]                   prod;
  logic [3:0]                    qx10_lo;
  logic [3:0]                    rem;
  logic [3:0]                    rd_idx;
  logic [7:0]                    emit_char;

  // quotient by reciprocal, remainder from the low nibble only
  assign prod    = {32'b0, value} * {32'b0, fsip_pkg::RECIP10};
  assign qx10_lo = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign rem     = value[3:0] - qx10_lo;
  assign rd_idx  = cnt - 4'd1;

  // status to the sequencer
  always_comb begin
    st.disp     = fsip_pkg::dispatch(pending, fmt_data.format_char);
    st.arg_neg  = value[31];
    st.q_nz     = (q != '0);
    st.hex_more = (cnt != fsip_pkg::HexLastIdx);
    st.dec_more = (cnt != fsip_pkg::DecLastCnt);
    st.out_free = !chr_valid || !chr_stall;
  end

  // character select
  always_comb begin
    case (cmd.csel)
      fsip_pkg::CS_CH:    emit_char = ch;
      fsip_pkg::CS_ARG:   emit_char = value[7:0];
      fsip_pkg::CS_MINUS: emit_char = fsip_pkg::CH_MINUS;
      fsip_pkg::CS_ZERO:  emit_char = fsip_pkg::CH_ZERO;
      fsip_pkg::CS_LX:    emit_char = fsip_pkg::CH_SEL_X;
      fsip_pkg::CS_HEX:   emit_char = fsip_pkg::hex_char(value[31:28]);
      fsip_pkg::CS_DEC:   emit_char = fsip_pkg::CH_ZERO + {4'b0, dbuf[rd_idx]};
      default:            emit_char = ch;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      cnt       <= '0;
      chr_valid <= 1'b0;
    end else begin
      if (cmd.go && cmd.emit) chr_valid <= 1'b1;
      else if (!chr_stall)    chr_valid <= 1'b0;
      if (cmd.go) begin
        case (cmd.op)
          fsip_pkg::OP_LOAD: begin
            pending <= !pending && (fmt_data.format_char == fsip_pkg::CH_PERCENT);
            cnt     <= '0;
          end
          fsip_pkg::OP_DIV_STEP:  cnt <= cnt + 4'd1;
          fsip_pkg::OP_HEX_SHIFT: cnt <= cnt + 4'd1;
          fsip_pkg::OP_DEC_POP:   cnt <= cnt - 4'd1;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.go && cmd.emit) begin
      chr_data.out_char <= emit_char;
      chr_data.last     <= cmd.last;
    end
    if (cmd.go) begin
      case (cmd.op)
        fsip_pkg::OP_LOAD: begin
          ch    <= fmt_data.format_char;
          value <= fmt_data.argument;
        end
        fsip_pkg::OP_NEGATE: begin
          if (value[31]) value <= 32'd0 - value;
        end
        fsip_pkg::OP_MUL: q <= prod[63:fsip_pkg::RecipShift];
        fsip_pkg::OP_DIV_STEP: begin
          dbuf[cnt] <= rem;
          value     <= {{(32 - fsip_pkg::QuotW){1'b0}}, q};
        end
        fsip_pkg::OP_HEX_SHIFT: value <= {value[27:0], 4'b0000};
        default: ;
      endcase
    end
  end

  // digit counter stays within the buffer
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'd10)
    else $error("digit counter out of range");

  // remainder of the divide step is a decimal digit
  a_rem_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && cmd.op == fsip_pkg::OP_DIV_STEP) |-> (rem <= 4'd9))
    else $error("divide step remainder is not a decimal digit");

  // never pop from an empty digit buffer
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.go && cmd.op == fsip_pkg::OP_DEC_POP) |-> (cnt != 4'd0))
    else $error("digit pop with empty buffer");

endmodule

### hw/rtl/format_string_integer_printer.sv
// ---------------------------------------------------------------------------
// format_string_integer_printer: printf-style integer formatter
// Takes one format byte with a 32-bit argument per transaction and
// produces the characters it causes, the final one marked by last.
// ---------------------------------------------------------------------------
// Usage:
//   fmt channel: format_char plus argument; a byte is taken only while the
//   sequencer sits in its fetch step, fmt_stall is high otherwise.
//   chr channel: one character per transaction, last set on the final one
//   of each input byte. '%' and unknown selectors produce no transaction.
// Steps per input byte:
//   echo and %c: the fetch step, then an emitting step; the character
//   is registered. '%' and unknown selectors use only the fetch step.
//   %x: '0', 'x', then eight hex digits, one per cycle while not stalled.
//   %d: a sign step ('-' if negative), then for each of up to 10 digits a
//   multiply-by-reciprocal step and a remainder step, then the digits leave
//   one per cycle from the digit buffer while the output is not stalled.
// Reset clears the step counter, the pending-percent flag, the digit counter and chr_valid.
// While chr_stall is high the held character stays on chr_data and the
// sequencer waits at its next emitting step.
// ---------------------------------------------------------------------------
module format_string_integer_printer (
  input  logic                clk,
  input  logic                rst,
  input  logic                fmt_valid,
  output logic                fmt_stall,
  input  fsip_pkg::fsip_in_t  fmt_data,
  output logic                chr_valid,
  input  logic                chr_stall,
  output fsip_pkg::fsip_out_t chr_data
);

  fsip_pkg::fsip_cmd_t    cmd;
  fsip_pkg::fsip_status_t st;
  logic                   take_in;

  // only the fetch step takes a transaction
  assign fmt_stall = !take_in;

  fsip_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .fmt_valid (fmt_valid),
    .st        (st),
    .cmd       (cmd),
    .take_in   (take_in)
  );

  fsip_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .fmt_data  (fmt_data),
    .chr_stall (chr_stall),
    .st        (st),
    .chr_valid (chr_valid),
    .chr_data  (chr_data)
  );

endmodule

### tb/sv/format_string_integer_printer_checker.sv
// ---------------------------------------------------------------------------
// format_string_integer_printer_checker: output checker for the format printer
// Watches both channels. Each accepted format byte is run through a local
// model of the percent-conversion logic. The characters that byte should
// produce are queued, and every accepted output transaction is compared
// field by field with the oldest queued character.
// ---------------------------------------------------------------------------
module format_string_integer_printer_checker
  import fsip_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fmt_valid,
  input  logic      fmt_stall,
  input  fsip_in_t  fmt_data,
  input  logic      chr_valid,
  input  logic      chr_stall,
  input  fsip_out_t chr_data,
  output int        mismatches,
  output int        chars_due,
  output int        bytes_taken,
  output int        chars_taken
);

  localparam logic [7:0] LOWER_X    = "x";
  localparam logic [7:0] HEX_LETTER = "A";

  fsip_out_t chars_owed [$];
  fsip_out_t want;
  logic      pct_armed;
  int        n_bad;
  int        n_bytes;
  int        n_chars;

  // uppercase hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + {4'b0, v};
    return HEX_LETTER + {4'b0, v} - 8'd10;
  endfunction

  // characters one format byte produces, queued in order, last one flagged
  task automatic format_byte(input fsip_in_t item);
    logic [7:0]  line [11];
    logic [7:0]  digits [10];
    logic [31:0] mag;
    fsip_out_t   c;
    int          n;
    int          nd;
    n  = 0;
    nd = 0;
    if (!pct_armed) begin
      if (item.format_char == CH_PERCENT) begin
        pct_armed = 1'b1;
      end else begin
        line[0] = item.format_char;
        n = 1;
      end
    end else begin
      pct_armed = 1'b0;
      case (item.format_char)
        CH_SEL_C: begin
          line[0] = item.argument[7:0];
          n = 1;
        end
        CH_SEL_D: begin
          mag = item.argument;
          // sign first, then magnitude; 0x80000000 negates onto itself
          if (item.argument[31]) begin
            line[n] = CH_MINUS;
            n++;
            mag = -item.argument;
          end
          do begin
            digits[nd] = CH_ZERO + 8'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
          end while (mag != 0);
          while (nd > 0) begin
            nd--;
            line[n] = digits[nd];
            n++;
          end
        end
        CH_SEL_X: begin
          line[0] = CH_ZERO;
          line[1] = LOWER_X;
          n = 2;
          for (int s = 7; s >= 0; s--) begin
            line[n] = hex_digit(item.argument[4*s +: 4]);
            n++;
          end
        end
        default: begin
          // unknown selector, including a second percent: nothing out
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      c.out_char = line[i];
      c.last     = (i == n - 1);
      chars_owed.push_back(c);
    end
  endtask

  // compare output first, then queue what the accepted byte produces
  always @(posedge clk) begin
    if (rst) begin
      pct_armed = 1'b0;
      chars_owed.delete();
      n_bad   = 0;
      n_bytes = 0;
      n_chars = 0;
    end else begin
      if (chr_valid && !chr_stall) begin
        n_chars++;
        if (chars_owed.size() == 0) begin
          n_bad++;
          $display("%0t: unexpected character, expected none got %h last %b",
                   $time, chr_data.out_char, chr_data.last);
        end else begin
          want = chars_owed.pop_front();
          if (chr_data.out_char !== want.out_char) begin
            n_bad++;
            $display("%0t: out_char mismatch, expected %h got %h",
                     $time, want.out_char, chr_data.out_char);
          end
          if (chr_data.last !== want.last) begin
            n_bad++;
            $display("%0t: last mismatch, expected %b got %b",
                     $time, want.last, chr_data.last);
          end
        end
      end
      if (fmt_valid && !fmt_stall) begin
        n_bytes++;
        format_byte(fmt_data);
      end
    end
    mismatches  <= n_bad;
    chars_due   <= chars_owed.size();
    bytes_taken <= n_bytes;
    chars_taken <= n_chars;
  end

endmodule

### tb/sv/format_string_integer_printer_test.sv
// ---------------------------------------------------------------------------
// format_string_integer_printer_test: stimulus and verdict for the printer
// Sends directed format bytes covering every conversion and its extremes,
// then mostly well-formed random conversions under four idle mixes and a
// long output hold. Checking is done by the checker instance.
// ---------------------------------------------------------------------------
module format_string_integer_printer_test;
  import fsip_pkg::*;

  localparam int         IdleLimit  = 3000;
  localparam int         HoldCycles = 300;
  localparam int         TailCycles = 120;
  localparam int         PhaseItems = 60;
  localparam int         HoldItems  = 20;
  localparam logic [7:0] SEL_STRING = "s";
  localparam logic [7:0] PLAIN_A    = "A";

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      fmt_valid = 1'b0;
  logic      fmt_stall;
  fsip_in_t  fmt_data  = '0;
  logic      chr_valid;
  logic      chr_stall = 1'b0;
  fsip_out_t chr_data;

  int   src_idle_pct  = 0;
  int   rcv_stall_pct = 0;
  int   src_mix [4]   = '{0, 61, 0, 8};
  int   rcv_mix [4]   = '{0, 0, 61, 8};
  logic hold_trig     = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;

  int mismatches;
  int chars_due;
  int bytes_taken;
  int chars_taken;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  format_string_integer_printer u_dut (
    .clk       (clk),
    .rst       (rst),
    .fmt_valid (fmt_valid),
    .fmt_stall (fmt_stall),
    .fmt_data  (fmt_data),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr_data  (chr_data)
  );

  format_string_integer_printer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .fmt_valid   (fmt_valid),
    .fmt_stall   (fmt_stall),
    .fmt_data    (fmt_data),
    .chr_valid   (chr_valid),
    .chr_stall   (chr_stall),
    .chr_data    (chr_data),
    .mismatches  (mismatches),
    .chars_due   (chars_due),
    .bytes_taken (bytes_taken),
    .chars_taken (chars_taken)
  );

  // output side: long hold on request, random stall otherwise
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HoldCycles;
      chr_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      chr_stall <= 1'b1;
    end else begin
      chr_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (fmt_valid && !fmt_stall) || (chr_valid && !chr_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one format byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] ch, input logic [31:0] arg);
    fsip_in_t item;
    item.format_char = ch;
    item.argument    = arg;
    while ($urandom_range(99) < src_idle_pct) begin
      fmt_valid <= 1'b0;
      @(posedge clk);
    end
    fmt_valid <= 1'b1;
    fmt_data  <= item;
    @(posedge clk);
    while (fmt_stall) @(posedge clk);
  endtask

  task automatic send_conv(input logic [7:0] sel, input logic [31:0] arg);
    send_byte(CH_PERCENT, $urandom);
    send_byte(sel, arg);
  endtask

  // stop sending until every queued character has come out
  task automatic wait_drained();
    fmt_valid <= 1'b0;
    do @(posedge clk); while (chars_due != 0);
  endtask

  // argument biased toward digit-count and sign boundaries
  function automatic logic [31:0] pick_argument();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(7))
      0: return $urandom_range(9);
      1: return $urandom_range(99999);
      2: return -$urandom_range(1, 1000);
      3: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      4: begin
        repeat ($urandom_range(9)) p = p * 32'd10;
        return p - $urandom_range(1);
      end
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed conversions, some echo, some broken selectors
  task automatic random_token();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      send_byte(8'($urandom_range(255)), $urandom);
    end else if (r < 85) begin
      case ($urandom_range(2))
        0: send_conv(CH_SEL_C, $urandom);
        1: send_conv(CH_SEL_D, pick_argument());
        default: send_conv(CH_SEL_X, pick_argument());
      endcase
    end else if (r < 93) begin
      send_conv(8'($urandom_range(255)), $urandom);
    end else begin
      send_conv(($urandom_range(1) != 0) ? CH_PERCENT : SEL_STRING, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: echo extremes, each conversion at its edges, bad selectors
    send_byte(PLAIN_A, $urandom);
    send_byte(8'h00, $urandom);
    send_byte(8'hff, $urandom);
    send_conv(CH_SEL_C, 32'h0000_0041);
    send_conv(CH_SEL_C, 32'hffff_ff00);
    send_conv(CH_SEL_D, 32'h0);
    send_conv(CH_SEL_D, 32'h8000_0000);
    send_conv(CH_SEL_D, 32'h7fff_ffff);
    send_conv(CH_SEL_D, 32'hffff_ffff);
    send_conv(CH_SEL_X, 32'h0);
    send_conv(CH_SEL_X, 32'hffff_ffff);
    send_conv(CH_PERCENT, $urandom);
    send_conv(SEL_STRING, $urandom);
    wait_drained();

    // random traffic under each idle mix
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_mix[p];
      rcv_stall_pct = rcv_mix[p];
      for (int i = 0; i < PhaseItems; i++) random_token();
      if (p == 0) begin
        // output held off while input keeps coming, so the block backs up
        hold_trig <= ~hold_trig;
        for (int i = 0; i < HoldItems; i++) random_token();
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    $display("covered %0d format bytes and %0d characters: all conversions, four idle mixes,",
             bytes_taken, chars_taken);
    $display("and a %0d-cycle output hold with the input backed up", HoldCycles);
    if (mismatches == 0 && chars_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fsip_pkg.sv
hw/rtl/fsip_seq.sv
hw/rtl/fsip_dp.sv
hw/rtl/format_string_integer_printer.sv
tb/sv/format_string_integer_printer_checker.sv
tb/sv/format_string_integer_printer_test.sv
